/* rtl/cqr_pkg.sv */
// cqr_pkg: command and status codes, field widths and the control/status
// structs shared by the circular queue controller, datapath and top level.
// No dependencies.
`default_nettype none

package cqr_pkg;

  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // front value reported for an empty queue
  localparam logic signed [VALUE_W-1:0] EMPTY_FRONT = 32'sd1;

  // controller to datapath
  typedef struct packed {
    logic load;      // item accepted this cycle
    logic rd_front;  // read the front slot
    logic rd_lo;     // read the low swap slot
    logic rd_hi;     // read the high swap slot
    logic wr_lo;     // write the high word into the low slot
    logic wr_hi;     // write the low word into the high slot, step pointers
    logic emit;      // load the result register
  } cqr_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic rev_loop;   // accepted item is a reverse with two or more entries
    logic swap_last;  // the current swap is the last one
    logic out_free;   // result register can take a new result
  } cqr_stat_t;

endpackage

`default_nettype wire

/* rtl/cqr_if.sv */
// cqr_in_if / cqr_out_if: valid/ready channels for the queue's items.
// Depends on cqr_pkg for field widths.
`default_nettype none

interface cqr_in_if
  import cqr_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface cqr_out_if
  import cqr_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] front_value;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, front_value, status, count, input ready);
  modport sink   (input valid, front_value, status, count, output ready);
endinterface

`default_nettype wire

/* rtl/cqr_ram.sv */
// cqr_ram: generic single write port, single read port RAM with a
// registered, enabled read. No dependencies.
`default_nettype none

module cqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/cqr_ctrl.sv */
// cqr_ctrl: sequencer for the circular queue; accepts items, steps the
// reverse swap loop and schedules the front read and the result.
// Depends on cqr_pkg.
`default_nettype none

module cqr_ctrl
  import cqr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire cqr_stat_t st,
  output      cqr_ctrl_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FRONT_RD = 3'd1;
  localparam logic [2:0] S_EMIT     = 3'd2;
  localparam logic [2:0] S_RD_LO    = 3'd3;
  localparam logic [2:0] S_RD_HI    = 3'd4;
  localparam logic [2:0] S_WR_LO    = 3'd5;
  localparam logic [2:0] S_WR_HI    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = st.rev_loop ? S_RD_LO : S_FRONT_RD;
        end
      end
      S_FRONT_RD: begin
        cmd.rd_front = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.rd_hi  = 1'b1;
        state_next = S_WR_LO;
      end
      S_WR_LO: begin
        cmd.wr_lo  = 1'b1;
        state_next = S_WR_HI;
      end
      S_WR_HI: begin
        cmd.wr_hi  = 1'b1;
        state_next = st.swap_last ? S_FRONT_RD : S_RD_LO;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a result is only written into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("result loaded while result register busy");

  // the front read is always followed by the result stage
  a_front_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_front |=> (state == S_EMIT))
    else $error("front read not followed by result stage");

endmodule

`default_nettype wire

/* rtl/cqr_dp.sv */
// cqr_dp: queue datapath; head/tail indices, swap pointers, storage RAM
// and the result register. Depends on cqr_pkg and cqr_ram.
`default_nettype none

module cqr_dp
  import cqr_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cqr_ctrl_t                 cmd,
  output      cqr_stat_t                 st,
  input  wire logic [CMD_W-1:0]          command,
  input  wire logic signed [VALUE_W-1:0] value,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic signed [VALUE_W-1:0] front_value,
  output      logic [STATUS_W-1:0]       status,
  output      logic [COUNT_W-1:0]        count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  logic [AW-1:0]       head;
  logic [AW-1:0]       tail;
  logic [AW-1:0]       lo;
  logic [AW-1:0]       hi;
  logic [AW-1:0]       swaps;
  logic [STATUS_W-1:0] status_q;
  logic [VALUE_W-1:0]  tmp;

  logic [CW-1:0]       cnt;
  logic                empty;
  logic                full;
  logic [AW-1:0]       tail_inc;
  logic [AW-1:0]       head_inc;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;

  assign tail_inc = ring_next(tail);
  assign head_inc = ring_next(head);
  assign empty    = (head == tail);
  assign full     = (tail_inc == head);
  assign cnt      = (tail >= head) ? CW'(tail) - CW'(head)
                                   : CW'(tail) + CW'(DEPTH) - CW'(head);

  assign st.rev_loop  = (command == CMD_REVERSE) && (cnt >= CW'(2));
  assign st.swap_last = (swaps == AW'(1));
  assign st.out_free  = !out_valid || out_ready;

  // storage port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_inc;
    ram_wdata = value;
    if (cmd.load && (command == CMD_ENQ) && !full) begin
      ram_we = 1'b1;
    end else if (cmd.wr_lo) begin
      ram_we    = 1'b1;
      ram_waddr = lo;
      ram_wdata = ram_rdata;
    end else if (cmd.wr_hi) begin
      ram_we    = 1'b1;
      ram_waddr = hi;
      ram_wdata = tmp;
    end
  end

  assign ram_re    = cmd.rd_front || cmd.rd_lo || cmd.rd_hi;
  assign ram_raddr = cmd.rd_front ? head_inc : (cmd.rd_lo ? lo : hi);

  cqr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // indices
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (cmd.load) begin
      case (command)
        CMD_ENQ: begin
          if (!full) begin
            tail <= tail_inc;
          end
        end
        CMD_DEQ: begin
          if (!empty) begin
            if (head_inc == tail) begin
              head <= '0;
              tail <= '0;
            end else begin
              head <= head_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // swap pointers and held status
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo    <= head_inc;
      hi    <= tail;
      swaps <= AW'(cnt >> 1);
      case (command)
        CMD_ENQ:  status_q <= full ? ST_FULL : ST_OK;
        CMD_DEQ:  status_q <= empty ? ST_EMPTY : ST_OK;
        CMD_PEEK: status_q <= empty ? ST_EMPTY : ST_OK;
        default:  status_q <= ST_OK;
      endcase
    end else if (cmd.wr_hi) begin
      lo    <= ring_next(lo);
      hi    <= ring_prev(hi);
      swaps <= swaps - AW'(1);
    end
    if (cmd.rd_hi) begin
      tmp <= ram_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      front_value <= empty ? EMPTY_FRONT : ram_rdata;
      status      <= status_q;
      count       <= COUNT_W'(cnt);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt < CW'(DEPTH))
    else $error("entry count out of range");

  a_empty_at_zero: assert property (@(posedge clk) disable iff (rst)
    empty |-> (head == '0))
    else $error("empty queue with nonzero head");

  a_swap_ptrs: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_lo |-> (lo != hi))
    else $error("swap pointers met");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result not presented after load");

endmodule

`default_nettype wire

/* rtl/circular_queue_with_reverse.sv */
// circular_queue_with_reverse: top level of the ring-buffer queue.
// Depends on cqr_pkg, cqr_if, cqr_ram, cqr_ctrl and cqr_dp.
`default_nettype none

// Ring-buffer queue of signed 32-bit words holding up to DEPTH-1 entries.
// Each input item carries a command (enqueue, dequeue, peek, reverse) and a
// word; each item yields exactly one result item with the front value (1
// when empty), a status (ok, full on enqueue, empty on dequeue or peek) and
// the entry count modulo 8. Enqueue, dequeue, peek and reverse of fewer
// than two entries pass from accept to result as: accept with index
// update, front read from the storage RAM, result load. Reverse of two or
// more entries swaps the oldest and newest unswapped entries in place
// before the front read and result load; each swap costs two reads and two
// writes on the single read and single write port of the storage RAM. The
// next item is accepted once the result is loaded, while that result still
// waits in the output register. The storage needs no clearing after reset.
module circular_queue_with_reverse
  import cqr_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input wire logic  clk,
  input wire logic  rst,
  cqr_in_if.sink    in_ch,
  cqr_out_if.source out_ch
);

  cqr_ctrl_t ctrl_cmd;
  cqr_stat_t dp_stat;
  logic      in_ready;

  // input handshake is owned by the sequencer
  assign in_ch.ready = in_ready;

  cqr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (dp_stat),
    .cmd      (ctrl_cmd)
  );

  // indices, storage and the output register
  cqr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctrl_cmd),
    .st          (dp_stat),
    .command     (in_ch.command),
    .value       (in_ch.value),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .front_value (out_ch.front_value),
    .status      (out_ch.status),
    .count       (out_ch.count)
  );

endmodule

`default_nettype wire

/* verif/tb_circular_queue_with_reverse.sv */
// tb_circular_queue_with_reverse: self-checking testbench for the ring-buffer queue
// with in-place reverse. Needs cqr_pkg, the cqr_in_if/cqr_out_if channel interfaces
// and the circular_queue_with_reverse top level with its submodules.
`default_nettype none

module tb_circular_queue_with_reverse
  import cqr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH   = 8;
  localparam int RESET_CYCLES  = 4;
  localparam int RANDOM_ITEMS  = 1425;
  // settle time after the last expectation is consumed, covering any straggler
  localparam int SETTLE_CYCLES = 40;
  // worst item: longest sender gap + a full-queue reverse + long receiver stall, ~1450 items
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  // one result item as the block reports it
  typedef struct packed {
    logic signed [VALUE_W-1:0] front;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;
  } queue_report_t;

  // one row of the directed walk; typed rows carry an expectation read off by hand
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] word;
    logic                      typed;
    queue_report_t             report;
  } directed_row_t;

  localparam int DIRECTED_COUNT = 25;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // fresh out of reset: empty queue reads front 1
    '{CMD_PEEK,    32'sh5a5a5a5a, 1'b1, '{EMPTY_FRONT,    ST_EMPTY, 3'd0}},
    '{CMD_DEQ,     32'shffffffff, 1'b1, '{EMPTY_FRONT,    ST_EMPTY, 3'd0}},
    // reverse of an empty queue is still ok
    '{CMD_REVERSE, 32'sh00000000, 1'b1, '{EMPTY_FRONT,    ST_OK,    3'd0}},
    '{CMD_ENQ,     32'sh7fffffff, 1'b1, '{32'sh7fffffff,  ST_OK,    3'd1}},
    // reverse of a single entry changes nothing visible
    '{CMD_REVERSE, 32'sh80000000, 1'b1, '{32'sh7fffffff,  ST_OK,    3'd1}},
    '{CMD_ENQ,     32'sh80000000, 1'b1, '{32'sh7fffffff,  ST_OK,    3'd2}},
    '{CMD_ENQ,     32'sh00000000, 1'b1, '{32'sh7fffffff,  ST_OK,    3'd3}},
    '{CMD_ENQ,     32'shffffffff, 1'b1, '{32'sh7fffffff,  ST_OK,    3'd4}},
    '{CMD_ENQ,     32'sh00000001, 1'b1, '{32'sh7fffffff,  ST_OK,    3'd5}},
    '{CMD_ENQ,     32'sh55555555, 1'b1, '{32'sh7fffffff,  ST_OK,    3'd6}},
    '{CMD_ENQ,     32'shaaaaaaaa, 1'b1, '{32'sh7fffffff,  ST_OK,    3'd7}},
    // full: word dropped
    '{CMD_ENQ,     32'sh12345678, 1'b1, '{32'sh7fffffff,  ST_FULL,  3'd7}},
    // odd-sized reverse of a full queue: newest becomes front
    '{CMD_REVERSE, 32'sh00000000, 1'b1, '{32'shaaaaaaaa,  ST_OK,    3'd7}},
    '{CMD_PEEK,    32'sh7fffffff, 1'b0, '0},
    '{CMD_DEQ,     32'sh00000000, 1'b0, '0},
    '{CMD_DEQ,     32'sh00000000, 1'b0, '0},
    '{CMD_DEQ,     32'sh80000000, 1'b0, '0},
    // even-sized reverse
    '{CMD_REVERSE, 32'shffffffff, 1'b0, '0},
    '{CMD_ENQ,     32'sh0badcafe, 1'b0, '0},
    '{CMD_DEQ,     32'sh00000000, 1'b0, '0},
    '{CMD_DEQ,     32'sh00000000, 1'b0, '0},
    '{CMD_DEQ,     32'sh00000000, 1'b0, '0},
    '{CMD_DEQ,     32'sh00000000, 1'b0, '0},
    // last dequeue empties the queue, indices fall back to zero
    '{CMD_DEQ,     32'sh00000000, 1'b1, '{EMPTY_FRONT,    ST_OK,    3'd0}},
    '{CMD_ENQ,     32'shdeadbeef, 1'b1, '{32'shdeadbeef,  ST_OK,    3'd1}}
  };

  logic clk;
  logic rst;

  cqr_in_if  in_ch ();
  cqr_out_if out_ch ();

  circular_queue_with_reverse #(
    .DEPTH (QUEUE_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the ring: slot storage plus head/tail indices
  logic signed [VALUE_W-1:0] ring_slots [QUEUE_DEPTH];
  int head_idx = 0;
  int tail_idx = 0;

  queue_report_t pending_reports [$];
  int mismatches  = 0;
  int cycle_count = 0;

  // applies one command to the shadow ring and returns the report it should produce
  function automatic queue_report_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [VALUE_W-1:0] word);
    queue_report_t             rep;
    logic signed [VALUE_W-1:0] held [QUEUE_DEPTH];
    int                        held_n;
    rep.status = ST_OK;
    case (cmd)
      CMD_ENQ: begin
        if ((tail_idx + 1) % QUEUE_DEPTH == head_idx) begin
          rep.status = ST_FULL;
        end else begin
          tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
          ring_slots[tail_idx] = word;
        end
      end
      CMD_DEQ: begin
        if (head_idx == tail_idx) begin
          rep.status = ST_EMPTY;
        end else begin
          head_idx = (head_idx + 1) % QUEUE_DEPTH;
          // emptied queue snaps both indices back to slot zero
          if (head_idx == tail_idx) begin
            head_idx = 0;
            tail_idx = 0;
          end
        end
      end
      CMD_PEEK: begin
        if (head_idx == tail_idx) rep.status = ST_EMPTY;
      end
      CMD_REVERSE: begin
        if (head_idx != tail_idx) begin
          held_n = (tail_idx + QUEUE_DEPTH - head_idx) % QUEUE_DEPTH;
          // walk from newest to oldest, then lay out newest-first from slot 1
          for (int i = 0; i < held_n; i++)
            held[i] = ring_slots[(tail_idx - i + QUEUE_DEPTH) % QUEUE_DEPTH];
          for (int i = 0; i < held_n; i++)
            ring_slots[(i + 1) % QUEUE_DEPTH] = held[i];
          head_idx = 0;
          tail_idx = held_n % QUEUE_DEPTH;
        end
      end
      default: ;
    endcase
    rep.front = (head_idx == tail_idx) ? EMPTY_FRONT
                                       : ring_slots[(head_idx + 1) % QUEUE_DEPTH];
    rep.count = COUNT_W'((tail_idx + QUEUE_DEPTH - head_idx) % QUEUE_DEPTH);
    return rep;
  endfunction

  // present one item, hold it until accepted, then log what it should produce;
  // typed rows override the shadow ring's answer with the hand-written one
  task automatic drive_item(input logic [CMD_W-1:0] cmd,
                            input logic signed [VALUE_W-1:0] word,
                            input logic typed,
                            input queue_report_t typed_report);
    queue_report_t predicted;
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = apply_command(cmd, word);
    pending_reports.push_back(typed ? typed_report : predicted);
  endtask

  // drop valid for a few cycles with junk on the payload
  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.command <= CMD_W'($urandom);
      in_ch.value   <= $urandom;
      repeat (cycles) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: stretches of always-ready, light stalls and heavy stalls
  initial begin
    int stretch;
    int mode;
    out_ch.ready = 1'b0;
    forever begin
      stretch = $urandom_range(100, 20);
      mode    = $urandom_range(2, 0);
      repeat (stretch) begin
        @(posedge clk);
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(9, 0) < 7);
          default: out_ch.ready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // result checker: every accepted result item pops the oldest expectation
  always @(posedge clk) begin
    queue_report_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result front=%h status=%0d count=%0d", $realtime,
                   out_ch.front_value, out_ch.status, out_ch.count);
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.front_value !== want.front || out_ch.status !== want.status ||
            out_ch.count !== want.count) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: front exp %h got %h, status exp %0d got %0d, count exp %0d got %0d",
                     $realtime, want.front, out_ch.front_value, want.status, out_ch.status,
                     want.count, out_ch.count);
        end
      end
    end
  end

  // stimulus: reset, directed walk, then random bursts
  initial begin
    int sent;
    int burst;
    int mix;
    int pick;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] word;

    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_ENQ;
    in_ch.value   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      drive_item(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].typed,
                 DIRECTED_ROWS[r].report);
      if ($urandom_range(1, 0) == 1) idle_sender($urandom_range(3, 1));
    end

    // mix 0 leans toward filling, 1 toward draining, 2 is balanced; the swing
    // keeps the queue moving between empty and full so wraps and reverses at
    // every fill level get exercised
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(24, 1);
      mix   = $urandom_range(2, 0);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(99, 0);
        case (mix)
          0:       cmd = (pick < 60) ? CMD_ENQ : (pick < 75) ? CMD_DEQ :
                         (pick < 88) ? CMD_PEEK : CMD_REVERSE;
          1:       cmd = (pick < 15) ? CMD_ENQ : (pick < 75) ? CMD_DEQ :
                         (pick < 88) ? CMD_PEEK : CMD_REVERSE;
          default: cmd = (pick < 35) ? CMD_ENQ : (pick < 70) ? CMD_DEQ :
                         (pick < 85) ? CMD_PEEK : CMD_REVERSE;
        endcase
        // sprinkle in corner words now and then
        case ($urandom_range(15, 0))
          0:       word = 32'sh7fffffff;
          1:       word = 32'sh80000000;
          2:       word = 32'sh00000000;
          3:       word = 32'shffffffff;
          4:       word = 32'sh00000001;
          default: word = $urandom;
        endcase
        drive_item(cmd, word, 1'b0, '0);
        sent++;
      end
      // about a quarter of bursts run straight into the next one
      if ($urandom_range(3, 0) != 0) idle_sender($urandom_range(12, 1));
    end
    idle_sender(1);

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
